FILE: design/aabb_collision_table_assert.svh
// Assertion macros shared by the checker of the box table.
`ifndef AABB_COLLISION_TABLE_ASSERT_SVH
`define AABB_COLLISION_TABLE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define AABB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box table check failed");

// The consequent must hold in the same cycle as the antecedent.
`define AABB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box table check failed");

`endif

FILE: design/aabb_ct_pkg.sv
package aabb_ct_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int SLOT_W    = 6;
  localparam int POS_W     = 16;
  localparam int SIZE_W    = 15;
  localparam int BND_W     = 19;
  localparam int CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic rm;
    logic scan_run;
    logic res_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             found;
    logic             last;
  } dp_status_t;

endpackage

FILE: design/aabb_ct_ifs.sv
interface aabb_ct_req_if
  import aabb_ct_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [SLOT_W-1:0]        slot;
  logic signed [POS_W-1:0]  parent_x;
  logic signed [POS_W-1:0]  parent_y;
  logic signed [POS_W-1:0]  offset_x;
  logic signed [POS_W-1:0]  offset_y;
  logic [SIZE_W-1:0]        box_width;
  logic [SIZE_W-1:0]        box_height;

  modport source (output valid, command, slot, parent_x, parent_y, offset_x, offset_y,
                  box_width, box_height, input ready);
  modport sink (input valid, command, slot, parent_x, parent_y, offset_x, offset_y,
                box_width, box_height, output ready);
endinterface

interface aabb_ct_rsp_if
  import aabb_ct_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  modport source (output valid, hit, hit_slot, input ready);
  modport sink (input valid, hit, hit_slot, output ready);
endinterface

FILE: design/aabb_ct_ctrl.sv
module aabb_ct_ctrl
  import aabb_ct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_code_t'(status.cmd))
          CMD_WRITE: begin
            ctrl.wr    = 1'b1;
            state_next = ST_DONE;
          end
          CMD_REMOVE: begin
            ctrl.rm    = 1'b1;
            state_next = ST_DONE;
          end
          CMD_QUERY: begin
            ctrl.scan_run = 1'b1;
            state_next    = ST_SCAN;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (status.found || status.last) begin
          state_next = ST_DONE;
        end else begin
          ctrl.scan_run = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.res_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/aabb_ct_dp.sv
module aabb_ct_dp
  import aabb_ct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_ctrl_t                ctrl,
  output dp_status_t              status,
  input  logic [CMD_W-1:0]        command,
  input  logic [SLOT_W-1:0]       slot,
  input  logic signed [POS_W-1:0] parent_x,
  input  logic signed [POS_W-1:0] parent_y,
  input  logic signed [POS_W-1:0] offset_x,
  input  logic signed [POS_W-1:0] offset_y,
  input  logic [SIZE_W-1:0]       box_width,
  input  logic [SIZE_W-1:0]       box_height,
  output logic                    hit,
  output logic [SLOT_W-1:0]       hit_slot
);

  localparam int EXT_W = IDX_W + SLOT_W;
  localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_BOXES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);

  logic [CMD_W-1:0]        q_cmd;
  logic [SLOT_W-1:0]       q_slot;
  logic signed [BND_W-1:0] q_xl, q_xh, q_yl, q_yh;

  logic signed [BND_W-1:0] xl_next, xh_next, yl_next, yh_next;

  logic [MAX_BOXES-1:0]    slot_valid;
  logic [4*BND_W-1:0]      bounds_mem [MAX_BOXES];
  logic [4*BND_W-1:0]      rd_data;

  logic [IDX_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        s1_idx;
  logic                    s1_live;
  logic                    s1_ok;

  logic [EXT_W-1:0]        slot_ext;
  logic [EXT_W-1:0]        scan_ext;
  logic [EXT_W-1:0]        s1_ext;
  logic [IDX_W-1:0]        slot_addr;
  logic                    slot_in_range;
  logic signed [BND_W-1:0] ol, oh, pl, ph;
  logic                    overlap;

  function automatic logic signed [BND_W-1:0] edge_dbl(
    input logic signed [POS_W-1:0] par,
    input logic signed [POS_W-1:0] off,
    input logic [SIZE_W-1:0]       size,
    input logic                    upper
  );
    logic signed [POS_W:0]   centre;
    logic signed [BND_W-1:0] c2;
    logic signed [BND_W-1:0] s;
    centre = {par[POS_W-1], par} + {off[POS_W-1], off};
    c2     = {centre[POS_W], centre, 1'b0};
    s      = {{(BND_W-SIZE_W){1'b0}}, size};
    edge_dbl = upper ? (c2 + s) : (c2 - s);
  endfunction

  assign xl_next = edge_dbl(parent_x, offset_x, box_width, 1'b0);
  assign xh_next = edge_dbl(parent_x, offset_x, box_width, 1'b1);
  assign yl_next = edge_dbl(parent_y, offset_y, box_height, 1'b0);
  assign yh_next = edge_dbl(parent_y, offset_y, box_height, 1'b1);

  assign slot_ext      = {{IDX_W{1'b0}}, q_slot};
  assign scan_ext      = {{SLOT_W{1'b0}}, scan_idx};
  assign s1_ext        = {{SLOT_W{1'b0}}, s1_idx};
  assign slot_addr     = slot_ext[IDX_W-1:0];
  assign slot_in_range = (slot_ext < MAX_EXT);

  assign ol = rd_data[BND_W-1:0];
  assign oh = rd_data[2*BND_W-1:BND_W];
  assign pl = rd_data[3*BND_W-1:2*BND_W];
  assign ph = rd_data[4*BND_W-1:3*BND_W];

  assign overlap = (q_xl <= oh) && (q_xh >= ol) && (q_yl <= ph) && (q_yh >= pl);

  assign status.cmd   = q_cmd;
  assign status.found = s1_live && s1_ok && overlap;
  assign status.last  = s1_live && (s1_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_cmd  <= command;
      q_slot <= slot;
      q_xl   <= xl_next;
      q_xh   <= xh_next;
      q_yl   <= yl_next;
      q_yh   <= yh_next;
    end
    if (ctrl.wr && slot_in_range) begin
      bounds_mem[slot_addr] <= {q_yh, q_yl, q_xh, q_xl};
    end
    if (ctrl.scan_run) begin
      rd_data <= bounds_mem[scan_idx];
      s1_idx  <= scan_idx;
      s1_ok   <= slot_valid[scan_idx] && (scan_ext != slot_ext);
    end
    if (ctrl.res_load) begin
      hit      <= status.found;
      hit_slot <= status.found ? s1_ext[SLOT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      scan_idx   <= '0;
      s1_live    <= 1'b0;
    end else begin
      if (ctrl.wr && slot_in_range) begin
        slot_valid[slot_addr] <= 1'b1;
      end
      if (ctrl.rm && slot_in_range) begin
        slot_valid[slot_addr] <= 1'b0;
      end
      if (ctrl.load) begin
        scan_idx <= '0;
        s1_live  <= 1'b0;
      end else if (ctrl.scan_run) begin
        scan_idx <= scan_idx + IDX_W'(1);
        s1_live  <= 1'b1;
      end
    end
  end

endmodule

FILE: design/aabb_collision_table.sv
// Channel  Dir  Word
// req      in   command, slot, parent_x/y, offset_x/y, box_width, box_height
// rsp      out  hit, hit_slot
//
// A write, remove or unused command runs through EXEC and then DONE.
// A query reads the box memory one slot per cycle until the last slot,
// or until an overlap is found earlier.
// Reset is synchronous and clears all slot valid bits.
// A result waits in the output register while the next word is accepted.
module aabb_collision_table
  import aabb_ct_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  aabb_ct_req_if.sink   req,
  aabb_ct_rsp_if.source rsp
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  aabb_ct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  aabb_ct_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .command    (req.command),
    .slot       (req.slot),
    .parent_x   (req.parent_x),
    .parent_y   (req.parent_y),
    .offset_x   (req.offset_x),
    .offset_y   (req.offset_y),
    .box_width  (req.box_width),
    .box_height (req.box_height),
    .hit        (rsp.hit),
    .hit_slot   (rsp.hit_slot)
  );

endmodule

FILE: design/aabb_ct_checker.sv
`include "aabb_collision_table_assert.svh"

module aabb_ct_checker
  import aabb_ct_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              hit,
  input logic [SLOT_W-1:0] hit_slot
);

  // The block works on one word at a time, so it is busy right after taking one.
  `AABB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A miss always reports slot zero.
  `AABB_ASSERT_NOW(a_miss_slot_zero, out_valid && !hit, hit_slot == '0)

  `AABB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  `AABB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(hit) && $stable(hit_slot))

endmodule

bind aabb_collision_table aabb_ct_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .hit       (rsp.hit),
  .hit_slot  (rsp.hit_slot)
);
